// ----- sv/rduf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rduf_pkg
// Shared constants, types and helpers for the RGB delta-undo filter.
// ----------------------------------------------------------------------------
package rduf_pkg;

  // Line store depth and the widths that follow from it
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Fixed field and register widths
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int LW_W   = 12;
  localparam int FH_W   = 16;
  localparam int ROW_W  = 16;

  // Width used to compare column positions against the row width
  localparam int CMP_W  = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;

  // APB port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes (word address bit 2)
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Reset values
  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = LW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  // Pixel: red in the low byte, then green, then blue
  typedef logic [PIX_W-1:0] pix_t;

  // Add two pixels channel by channel, each modulo 256
  function automatic pix_t add_rgb(input pix_t a, input pix_t b);
    pix_t s;
    for (int i = 0; i < 3; i++) begin
      s[i*CH_W +: CH_W] = a[i*CH_W +: CH_W] + b[i*CH_W +: CH_W];
    end
    return s;
  endfunction

endpackage

// ----- sv/rgb_delta_undo_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_delta_undo_filter
// Undoes a row delta filter on an RGB raster stream: first row adds the left
// neighbor, later rows add the pixel above from a one-line store.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  in_     | in  | tvalid/tready      | tdata = red, green, blue
//  out_    | out | tvalid/tready      | tdata = red, green, blue; tlast
//  cfg_    | in  | APB psel/penable   | line_width @0x0, frame_height @0x4
//
//  One pixel per cycle sustained while the output is not stalled: the
//  line store read is issued when a pixel is taken, the sum is formed in the
//  next cycle and lands in the output register when the compute stage moves.
//  Reset clears counters, left pixel and valid flags; the line store is not
//  cleared. A stalled output holds both stages; the input side keeps taking
//  requests whenever the stage ahead moves.
// ----------------------------------------------------------------------------
module rgb_delta_undo_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rduf_pkg::PIX_W-1:0]  in_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  // Output stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rduf_pkg::PIX_W-1:0]  out_tdata,  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic                        out_tlast,  // frame_end
  // Configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rduf_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [rduf_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [rduf_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  import rduf_pkg::*;

  // Configuration registers
  logic [LW_W-1:0]  line_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic             cfg_wr;

  // Position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Compute stage
  logic             s1_vld_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_first_row_r;
  logic             s1_first_col_r;
  logic             s1_last_r;

  // Bypass for a line store entry written as it is read
  pix_t             byp_r;
  logic             byp_sel_r;

  // Left neighbor
  pix_t             left_r;

  // Output register
  logic             out_vld_r;
  pix_t             out_pix_r;
  logic             out_last_r;

  // Misc
  logic             in_acc;
  logic             s1_adv;
  logic [CMP_W-1:0] eff_width;
  logic [CMP_W-1:0] col_inc;
  logic [FH_W:0]    eff_height;
  logic [FH_W:0]    row_inc;
  logic             last_col;
  logic             last_row;
  pix_t             above;
  pix_t             rec;
  pix_t             ram_rdata;

  // APB: always ready, word addressed by bit 2
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_LINE_WIDTH:   line_width_r   <= cfg_pwdata[LW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_LINE_WIDTH:   cfg_prdata = APB_DW'(line_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = APB_DW'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Handshake: a stage moves when the one ahead is free or draining
  assign s1_adv    = s1_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~s1_vld_r | s1_adv;
  assign in_acc    = in_tvalid & in_tready;

  // Clamp width to 1..MAX_WIDTH and height to at least 1
  always_comb begin
    eff_width = CMP_W'(line_width_r);
    if (line_width_r == '0) begin
      eff_width = CMP_W'(1);
    end else if (CMP_W'(line_width_r) > CMP_W'(MAX_WIDTH)) begin
      eff_width = CMP_W'(MAX_WIDTH);
    end
    eff_height = (frame_height_r == '0) ? (FH_W+1)'(1) : (FH_W+1)'(frame_height_r);
  end

  // Row and frame end for the pixel being taken
  assign col_inc  = CMP_W'(col_r) + CMP_W'(1);
  assign row_inc  = (FH_W+1)'(row_r) + (FH_W+1)'(1);
  assign last_col = col_inc >= eff_width;
  assign last_row = row_inc >= eff_height;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store: read on request, write as each pixel leaves the compute stage
  rduf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (rec),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // Load the compute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      byp_sel_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r  <= 1'b1;
        byp_sel_r <= s1_adv & (s1_col_r == col_r);
      end else if (s1_adv) begin
        s1_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r       <= in_tdata;
      s1_col_r       <= col_r;
      s1_first_row_r <= (row_r == '0);
      s1_first_col_r <= (col_r == '0);
      s1_last_r      <= last_col & last_row;
      byp_r          <= rec;
    end
  end

  // Reconstruct: left neighbor in the first row (its first pixel passes through), pixel above elsewhere
  assign above = byp_sel_r ? byp_r : ram_rdata;

  always_comb begin
    if (s1_first_row_r) begin
      rec = s1_first_col_r ? s1_pix_r : add_rgb(s1_pix_r, left_r);
    end else begin
      rec = add_rgb(s1_pix_r, above);
    end
  end

  // Track the left neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1_adv) begin
      left_r <= rec;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r  <= rec;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/rduf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rduf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rduf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
